/* sv/sha1md_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Shared types, constants and round functions of the digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } sha1md_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } sha1md_rsp_type;

   // Control from the sequencer to the schedule and round units
   typedef struct packed {
      logic       shift_byte;
      logic [7:0] byte_val;
      logic       round_en;
      logic [6:0] round_idx;
      logic       load_work;
      logic       fold;
      logic       init_chain;
      logic [2:0] word_sel;
   } sha1md_ctl_type;

   localparam logic [0:4][31:0] SHA1MD_IV = {
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   localparam logic [6:0] SHA1MD_LAST_ROUND = 7'd79;
   localparam logic [2:0] SHA1MD_LAST_WORD  = 3'd4;
   localparam int unsigned SHA1MD_WORDS     = 5;

   function automatic logic [31:0] sha1md_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
      logic [31:0] res;
      if (t < 7'd20) begin
         res = (b & c) ^ (~b & d);
      end else if (t < 7'd40) begin
         res = b ^ c ^ d;
      end else if (t < 7'd60) begin
         res = (b & c) ^ (b & d) ^ (c & d);
      end else begin
         res = b ^ c ^ d;
      end
      return res;
   endfunction

   function automatic logic [31:0] sha1md_k(input logic [6:0] t);
      logic [31:0] res;
      if (t < 7'd20) begin
         res = 32'h5a827999;
      end else if (t < 7'd40) begin
         res = 32'h6ed9eba1;
      end else if (t < 7'd60) begin
         res = 32'h8f1bbcdc;
      end else begin
         res = 32'hca62c1d6;
      end
      return res;
   endfunction

endpackage

/* sv/sha1_message_digest.sv */
// ----------------------------------------------------------------------------
// SHA-1 message digest
// One message byte per transaction; pads, compresses and returns h0..h4.
// ----------------------------------------------------------------------------
// Compression: the 64th byte of a block starts the rounds and then the fold,
//   run by the single shared round unit; no byte is taken meanwhile.
// End transaction: up to 72 padding bytes (one byte a cycle) and one or two
//   compressions, then five result transactions h0 first.
// Reset: synchronous, active high; chain value returns to the initial vector,
//   counters clear, and req_ready is high from the first reset edge onward.
module sha1_message_digest
   import sha1md_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  sha1md_req_type req_item,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output sha1md_rsp_type rsp_item
);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROUND = 3'd1;
   localparam logic [2:0] S_FOLD  = 3'd2;
   localparam logic [2:0] S_PAD   = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   localparam logic [5:0] LAST_POS = 6'd63;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [7:0] PAD_MARK = 8'h80;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;          // byte offset within the block
   logic [6:0]  round_ff, round_in;
   logic [60:0] bytes_ff, bytes_in;      // message length in bytes
   logic [63:0] len_ff, len_in;          // bit length, shifted out during padding
   logic        ending_ff, ending_in;    // message has ended, padding under way
   logic        mark_ff, mark_in;        // 0x80 marker absorbed
   logic        fill_ff, fill_in;        // length bytes under way
   logic        done_ff, done_in;        // last length byte absorbed
   logic [2:0]  word_ff, word_in;

   sha1md_ctl_type ctl;
   logic [31:0]    w_t;
   logic [31:0]    digest_word;
   logic           len_byte;

   // The length field starts when the marker is in and offset 56 is reached
   assign len_byte = fill_ff || (mark_ff && (pos_ff == LEN_POS));

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      round_in  = round_ff;
      bytes_in  = bytes_ff;
      len_in    = len_ff;
      ending_in = ending_ff;
      mark_in   = mark_ff;
      fill_in   = fill_ff;
      done_in   = done_ff;
      word_in   = word_ff;
      ctl       = '0;
      ctl.round_idx = round_ff;
      ctl.word_sel  = word_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_item.byte_present) begin
                  // absorb the byte; a full block starts compression
                  ctl.shift_byte = 1'b1;
                  ctl.byte_val   = req_item.data_byte;
                  pos_in         = pos_ff + 6'd1;
                  bytes_in       = bytes_ff + 61'd1;
                  if (pos_ff == LAST_POS) begin
                     ctl.load_work = 1'b1;
                     round_in      = '0;
                     state_in      = S_ROUND;
                  end
               end
               if (req_item.end_of_message) begin
                  // capture the bit length including any byte taken now
                  ending_in = 1'b1;
                  len_in    = {bytes_ff + {60'd0, req_item.byte_present}, 3'b000};
                  if (!(req_item.byte_present && (pos_ff == LAST_POS))) begin
                     state_in = S_PAD;
                  end
               end
            end
         end
         S_ROUND: begin
            ctl.round_en = 1'b1;
            round_in     = round_ff + 7'd1;
            if (round_ff == SHA1MD_LAST_ROUND) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            // add the working variables into the chain value
            ctl.fold = 1'b1;
            round_in = '0;
            if (!ending_ff) begin
               state_in = S_IDLE;
            end else if (done_ff) begin
               word_in  = '0;
               state_in = S_OUT;
            end else begin
               state_in = S_PAD;
            end
         end
         S_PAD: begin
            // inject marker, zero fill, then the big-endian length
            ctl.shift_byte = 1'b1;
            pos_in         = pos_ff + 6'd1;
            if (!mark_ff) begin
               ctl.byte_val = PAD_MARK;
               mark_in      = 1'b1;
            end else if (len_byte) begin
               ctl.byte_val = len_ff[63:56];
               len_in       = {len_ff[55:0], 8'h00};
               fill_in      = 1'b1;
               if (pos_ff == LAST_POS) begin
                  done_in = 1'b1;
               end
            end else begin
               ctl.byte_val = 8'h00;
            end
            if (pos_ff == LAST_POS) begin
               ctl.load_work = 1'b1;
               round_in      = '0;
               state_in      = S_ROUND;
            end
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               word_in = word_ff + 3'd1;
               if (word_ff == SHA1MD_LAST_WORD) begin
                  // drop back to the reset state for the next message
                  ctl.init_chain = 1'b1;
                  pos_in    = '0;
                  bytes_in  = '0;
                  ending_in = 1'b0;
                  mark_in   = 1'b0;
                  fill_in   = 1'b0;
                  done_in   = 1'b0;
                  word_in   = '0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pos_ff    <= '0;
         round_ff  <= '0;
         bytes_ff  <= '0;
         ending_ff <= 1'b0;
         mark_ff   <= 1'b0;
         fill_ff   <= 1'b0;
         done_ff   <= 1'b0;
         word_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         round_ff  <= round_in;
         bytes_ff  <= bytes_in;
         ending_ff <= ending_in;
         mark_ff   <= mark_in;
         fill_ff   <= fill_in;
         done_ff   <= done_in;
         word_ff   <= word_in;
      end
   end

   // length is payload: only meaningful once the message has ended
   always_ff @(posedge clock) begin
      len_ff <= len_in;
   end

   sha1md_sched u_sched (
      .clock (clock),
      .ctl   (ctl),
      .w_t   (w_t)
   );

   sha1md_round u_round (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .w_t         (w_t),
      .digest_word (digest_word)
   );

   assign rsp_item.digest_word = digest_word;
   assign rsp_item.word_index  = word_ff;
   assign rsp_item.last_word   = (word_ff == SHA1MD_LAST_WORD);

endmodule

/* sv/sha1md_sched.sv */
// ----------------------------------------------------------------------------
// SHA-1 message schedule
// Sixteen-word window: bytes shift in big-endian, rounds shift words out
// and append the expanded word.
// ----------------------------------------------------------------------------
module sha1md_sched
   import sha1md_pkg::*;
(
   input  logic           clock,
   input  sha1md_ctl_type ctl,
   output logic [31:0]    w_t
);

   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [31:0] mix;

   assign mix = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign w_t = win_ff[0];

   always_comb begin
      win_in = win_ff;
      if (ctl.shift_byte) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = {win_ff[i][23:0], win_ff[i+1][31:24]};
         end
         win_in[15] = {win_ff[15][23:0], ctl.byte_val};
      end else if (ctl.round_en) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[15] = {mix[30:0], mix[31]};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

/* sv/sha1md_round.sv */
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Working variables a..e, one round per enabled cycle, and the chain value.
// ----------------------------------------------------------------------------
module sha1md_round
   import sha1md_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  sha1md_ctl_type ctl,
   input  logic [31:0]    w_t,
   output logic [31:0]    digest_word
);

   logic [31:0] work_ff  [SHA1MD_WORDS];
   logic [31:0] work_in  [SHA1MD_WORDS];
   logic [31:0] chain_ff [SHA1MD_WORDS];
   logic [31:0] chain_in [SHA1MD_WORDS];
   logic [31:0] temp;

   assign temp = {work_ff[0][26:0], work_ff[0][31:27]}
               + sha1md_f(ctl.round_idx, work_ff[1], work_ff[2], work_ff[3])
               + work_ff[4] + sha1md_k(ctl.round_idx) + w_t;

   always_comb begin
      work_in = work_ff;
      if (ctl.load_work) begin
         work_in = chain_ff;
      end else if (ctl.round_en) begin
         work_in[0] = temp;
         work_in[1] = work_ff[0];
         work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3];
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (ctl.init_chain) begin
         for (int i = 0; i < SHA1MD_WORDS; i++) begin
            chain_in[i] = SHA1MD_IV[i];
         end
      end else if (ctl.fold) begin
         for (int i = 0; i < SHA1MD_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (reset) begin
         for (int i = 0; i < SHA1MD_WORDS; i++) begin
            chain_ff[i] <= SHA1MD_IV[i];
         end
      end else begin
         chain_ff <= chain_in;
      end
   end

   assign digest_word = chain_ff[ctl.word_sel];

endmodule
